// File: rtl/image_diff_error_accumulator_assert.svh
// assertion macros, included by the controller
`ifndef IMAGE_DIFF_ERROR_ACCUMULATOR_ASSERT_SVH
`define IMAGE_DIFF_ERROR_ACCUMULATOR_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define IDEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define IDEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/idea_pkg.sv
package idea_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ErrW   = 18;
  localparam int unsigned TotalW = 39;

  // skip thresholds: full scale in l1, 0.999 of full scale in l2
  localparam logic [ErrW-1:0] L1Skip = ErrW'(765);
  localparam logic [ErrW-1:0] L2Skip = ErrW'(194880);

  typedef struct packed {
    logic [ChanW-1:0] ref_red;
    logic [ChanW-1:0] ref_green;
    logic [ChanW-1:0] ref_blue;
    logic [ChanW-1:0] test_red;
    logic [ChanW-1:0] test_green;
    logic [ChanW-1:0] test_blue;
    logic             last_pixel;
  } idea_in_t;

  typedef struct packed {
    logic [ChanW-1:0]  diff_red;
    logic [ChanW-1:0]  diff_green;
    logic [ChanW-1:0]  diff_blue;
    logic [TotalW-1:0] error_total;
    logic [ErrW-1:0]   error_peak;
    logic              image_done;
  } idea_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic do_diff;
    logic do_err;
    logic do_acc;
  } idea_cmd_t;

endpackage

// File: rtl/idea_ctrl.sv
module idea_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output idea_pkg::idea_cmd_t cmd_o
);
  import idea_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIFF = 2'd1;
  localparam logic [1:0] S_ERR  = 2'd2;
  localparam logic [1:0] S_ACC  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.do_diff = 1'b1;
        state_d       = S_ERR;
      end
      S_ERR: begin
        cmd_o.do_err = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd_o.do_acc = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "image_diff_error_accumulator_assert.svh"

  `IDEA_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_DIFF, "accept lost")
  `IDEA_ASSERT_NEXT(a_err_to_acc, state_q == S_ERR, state_q == S_ACC, "err stage skipped acc")
  `IDEA_ASSERT(a_acc_needs_room, !cmd_o.do_acc || !out_valid_q || out_ready_i, "result overrun")
  `IDEA_ASSERT_NEXT(a_acc_gives_item, cmd_o.do_acc, out_valid_o && state_q == S_IDLE, "no item")

endmodule

// File: rtl/idea_dp.sv
module idea_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_data_i,
  input  idea_pkg::idea_in_t  in_item_i,
  input  idea_pkg::idea_cmd_t cmd_i,
  output idea_pkg::idea_out_t out_item_o
);
  import idea_pkg::*;

  idea_in_t          in_q;
  idea_out_t         out_q;
  logic              mode_q;
  logic [ChanW-1:0]  diff_q [3];
  logic [ChanW-1:0]  diff_d [3];
  logic [ChanW-1:0]  ref_c  [3];
  logic [ChanW-1:0]  test_c [3];
  logic [15:0]       sq     [3];
  logic [ErrW-1:0]   err_q, err_d;
  logic [TotalW-1:0] total_q, total_d, total_sat;
  logic [ErrW-1:0]   peak_q, peak_d, peak_new;
  logic [TotalW:0]   total_sum;
  logic              skip;

  assign ref_c[0]  = in_q.ref_red;
  assign ref_c[1]  = in_q.ref_green;
  assign ref_c[2]  = in_q.ref_blue;
  assign test_c[0] = in_q.test_red;
  assign test_c[1] = in_q.test_green;
  assign test_c[2] = in_q.test_blue;

  // absolute difference, squared and clamped in l2 mode
  always_comb begin
    logic [ChanW-1:0] ad;
    logic [ChanW-1:0] sqs;
    for (int c = 0; c < 3; c++) begin
      ad  = (ref_c[c] > test_c[c]) ? ref_c[c] - test_c[c] : test_c[c] - ref_c[c];
      // a difference of 16 or more squares past 255
      sqs = (ad >= ChanW'(16)) ? {ChanW{1'b1}} : ad[3:0] * ad[3:0];
      diff_d[c] = mode_q ? sqs : ad;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq[c] = diff_q[c] * diff_q[c];
    end
    if (mode_q) begin
      err_d = ErrW'(sq[0]) + ErrW'(sq[1]) + ErrW'(sq[2]);
    end else begin
      err_d = ErrW'(diff_q[0]) + ErrW'(diff_q[1]) + ErrW'(diff_q[2]);
    end
  end

  assign skip      = err_q >= (mode_q ? L2Skip : L1Skip);
  assign total_sum = {1'b0, total_q} + (TotalW+1)'(err_q);
  assign total_sat = total_sum[TotalW] ? {TotalW{1'b1}} : total_sum[TotalW-1:0];
  assign peak_new  = (err_q > peak_q) ? err_q : peak_q;

  always_comb begin
    total_d = total_q;
    peak_d  = peak_q;
    if (cmd_i.do_acc) begin
      if (in_q.last_pixel) begin
        total_d = '0;
        peak_d  = '0;
      end else if (!skip) begin
        total_d = total_sat;
        peak_d  = peak_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      total_q <= '0;
      peak_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      total_q <= total_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    if (cmd_i.do_diff) begin
      diff_q <= diff_d;
    end
    if (cmd_i.do_err) begin
      err_q <= err_d;
    end
    if (cmd_i.do_acc) begin
      out_q.diff_red    <= diff_q[0];
      out_q.diff_green  <= diff_q[1];
      out_q.diff_blue   <= diff_q[2];
      out_q.error_total <= skip ? total_q : total_sat;
      out_q.error_peak  <= skip ? peak_q : peak_new;
      out_q.image_done  <= in_q.last_pixel;
    end
  end

  assign out_item_o = out_q;

endmodule

// File: rtl/image_diff_error_accumulator.sv
// channel   dir  handshake                  payload
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i (error_mode, 0 = l1, 1 = l2)
// in        in   in_valid_i / in_ready_o    in_item_i (reference and test pixel, last mark)
// out       out  out_valid_o / out_ready_i  out_item_o (difference pixel, total, peak, done)
//
// each item passes four steps: capture, channel difference, pixel error, accumulate
// the accumulate step is the only stage that waits for a stalled output
// the next item is taken while a finished result waits in the output register
// reset clears the total, the peak, the error mode and all handshake state
// configuration is always ready and is to be written while the block is idle; the block does not enforce this
module image_diff_error_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idea_pkg::idea_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idea_pkg::idea_out_t out_item_o
);
  import idea_pkg::*;

  idea_cmd_t cmd;

  // mode register takes every write at once
  assign cfg_ready_o = 1'b1;

  // sequencer: one item in flight, output register decoupled
  idea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // differences, error sum, saturating total and running peak
  idea_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import idea_pkg::*;

  // error mode as seen on the configuration port
  typedef enum logic {
    ModeL1 = 1'b0,
    ModeL2 = 1'b1
  } err_mode_e;

  // a pixel at or above these errors is skipped (full scale in l1, 0.999 of full scale in l2)
  localparam int unsigned SkipL1 = 765;
  localparam int unsigned SkipL2 = 194880;
  localparam longint unsigned TotalMax = 64'h0000_007F_FFFF_FFFF;

  localparam int unsigned SettleCycles = 8;   // beyond the four-stage pipe
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned HoldCycles   = 90;  // long output hold-off
  localparam int unsigned IdlePercent  = 24;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  idea_in_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  idea_out_t out_item_o;

  // predictor state, mirrors the accumulator and the mode register
  logic [38:0] image_err_total = '0;
  logic [17:0] image_err_peak  = '0;
  err_mode_e   active_mode     = ModeL1;

  idea_out_t expected_diff_results[$];
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  bit          idling_on      = 1'b1;

  image_diff_error_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned chan_abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // works out the result of one pixel and advances the running total and peak
  function automatic idea_out_t predict_diff_result(input idea_in_t px);
    idea_out_t       res;
    int unsigned     diff [3];
    int unsigned     pix_err;
    int unsigned     skip_at;
    longint unsigned sum;
    diff[0] = chan_abs_diff(px.ref_red, px.test_red);
    diff[1] = chan_abs_diff(px.ref_green, px.test_green);
    diff[2] = chan_abs_diff(px.ref_blue, px.test_blue);
    pix_err = 0;
    for (int c = 0; c < 3; c++) begin
      if (active_mode == ModeL2) begin
        // square, saturate at 255, then square again for the error
        diff[c] = diff[c] * diff[c];
        if (diff[c] > 255) diff[c] = 255;
        pix_err += diff[c] * diff[c];
      end else begin
        pix_err += diff[c];
      end
    end
    skip_at = (active_mode == ModeL2) ? SkipL2 : SkipL1;
    // near full-scale pixels leave total and peak alone
    if (pix_err < skip_at) begin
      sum = longint'(image_err_total) + longint'(pix_err);
      image_err_total = (sum > TotalMax) ? 39'(TotalMax) : 39'(sum);
      if (pix_err > image_err_peak) image_err_peak = 18'(pix_err);
    end
    res.diff_red    = 8'(diff[0]);
    res.diff_green  = 8'(diff[1]);
    res.diff_blue   = 8'(diff[2]);
    res.error_total = image_err_total;
    res.error_peak  = image_err_peak;
    res.image_done  = px.last_pixel;
    // totals clear once the last pixel of the image has been reported
    if (px.last_pixel) begin
      image_err_total = '0;
      image_err_peak  = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic idea_in_t build_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [7:0] tr,
                                           input logic [7:0] tg, input logic [7:0] tb,
                                           input logic last);
    idea_in_t px;
    px.ref_red    = r;
    px.ref_green  = g;
    px.ref_blue   = b;
    px.test_red   = tr;
    px.test_green = tg;
    px.test_blue  = tb;
    px.last_pixel = last;
    return px;
  endfunction

  // a value close to v, so that l2 squares do not always saturate
  function automatic logic [7:0] near_channel(input logic [7:0] v);
    int unsigned d;
    d = $urandom_range(0, 20);
    if ($urandom_range(0, 1) == 1 && int'(v) + d <= 255) return 8'(int'(v) + d);
    if (int'(v) >= d) return 8'(int'(v) - d);
    return 8'(int'(v) + d);
  endfunction

  function automatic idea_in_t random_pixel(input logic last);
    idea_in_t    px;
    int unsigned style;
    style = $urandom_range(0, 99);
    px = build_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), last);
    if (style < 50) begin
      // near match, the usual case when comparing similar images
      px.test_red   = near_channel(px.ref_red);
      px.test_green = near_channel(px.ref_green);
      px.test_blue  = near_channel(px.ref_blue);
    end else if (style < 65) begin
      // black and white corners, hits the skip threshold often
      px.ref_red    = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.ref_green  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.ref_blue   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.test_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.test_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.test_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  // offers one item and waits for it to be taken, then books its result
  task automatic send_pixel(input idea_in_t px);
    if (idling_on) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_diff_results = {expected_diff_results, predict_diff_result(px)};
    pixels_sent++;
  endtask

  task automatic send_image(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_pixel(random_pixel(i == len - 1));
  endtask

  // stops offering and waits until every booked result has come back
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_diff_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic set_error_mode(input err_mode_e mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    active_mode = mode;
  endtask

  // ---------------------------------------------------------------------------
  // result checking and output side idling
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input idea_out_t got);
    idea_out_t want;
    if (expected_diff_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %p", $time, got);
      mismatch_count++;
    end else begin
      want = expected_diff_results.pop_front();
      compare_field("diff_red", want.diff_red, got.diff_red);
      compare_field("diff_green", want.diff_green, got.diff_green);
      compare_field("diff_blue", want.diff_blue, got.diff_blue);
      compare_field("error_total", want.error_total, got.error_total);
      compare_field("error_peak", want.error_peak, got.error_peak);
      compare_field("image_done", want.image_done, got.image_done);
    end
  endtask

  // samples pre-edge values, then picks ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_item_o);
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (idling_on) begin
      out_ready_i <= ($urandom_range(0, 99) >= IdlePercent);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // l1 with the mode left at its reset value
  task automatic test_l1_corners();
    send_pixel(build_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(build_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0));   // full scale, skipped
    send_pixel(build_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0));   // same, other way round
    send_pixel(build_pixel(8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0, 1'b0));   // one below the skip
    send_pixel(build_pixel(8'd10, 8'd200, 8'd37, 8'd12, 8'd190, 8'd40, 1'b0));
    send_pixel(build_pixel(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1));
    send_pixel(build_pixel(8'd1, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0, 1'b0));         // totals cleared
    send_pixel(build_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1));   // skipped last pixel
    wait_until_drained();
  endtask

  task automatic test_l2_corners();
    set_error_mode(ModeL2);
    send_pixel(build_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(build_pixel(8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));        // 225, no saturation
    send_pixel(build_pixel(8'd16, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));        // 256 saturates
    send_pixel(build_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0));   // all saturated, skipped
    send_pixel(build_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd16, 1'b0));    // skipped too
    send_pixel(build_pixel(8'd255, 8'd255, 8'd15, 8'd0, 8'd0, 8'd0, 1'b0));    // largest counted error
    send_pixel(build_pixel(8'd1, 8'd2, 8'd3, 8'd2, 8'd4, 8'd6, 1'b1));
    send_pixel(build_pixel(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 1'b1));         // one-pixel image
    wait_until_drained();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_output_hold_off();
    set_error_mode(ModeL1);
    idling_on = 1'b0;
    hold_left = HoldCycles;
    send_image(25);
    send_image(15);
    idling_on = 1'b1;
    wait_until_drained();
  endtask

  // sender pauses mid-image until the pipe is empty, then carries on
  task automatic test_drained_pause();
    for (int unsigned i = 0; i < 15; i++) send_pixel(random_pixel(1'b0));
    wait_until_drained();
    send_image(15);
    wait_until_drained();
  endtask

  // random images in phases, switching the mode between them
  task automatic test_random_images();
    err_mode_e   phase_mode [4];
    int unsigned target;
    phase_mode[0] = ModeL2;
    phase_mode[1] = ModeL1;
    phase_mode[2] = ModeL2;
    phase_mode[3] = ModeL1;
    for (int p = 0; p < 4; p++) begin
      set_error_mode(phase_mode[p]);
      idling_on = (p != 2);   // one phase at full rate on both sides
      target = pixels_sent + 180;
      while (pixels_sent < target) begin
        // mostly short images, now and then a single pixel
        send_image($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 48));
      end
      wait_until_drained();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_l1_corners();
    test_l2_corners();
    test_output_hold_off();
    test_drained_pause();
    test_random_images();
    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/idea_pkg.sv
rtl/idea_ctrl.sv
rtl/idea_dp.sv
rtl/image_diff_error_accumulator.sv
tb/sv/testbench.sv
